/* rtl/gstage_page_table_walker_core_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the guest-stage page table walker
// Shared property forms, clocked on clk and disabled during rst_n low.
// ---------------------------------------------------------------------------
`ifndef GSTAGE_PAGE_TABLE_WALKER_CORE_DEFINES_SVH
`define GSTAGE_PAGE_TABLE_WALKER_CORE_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define GPTW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gptw: same-cycle check failed");

// consequent holds in the cycle after the antecedent
`define GPTW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gptw: next-cycle check failed");

`endif

/* rtl/gptw_pkg.sv */
// ---------------------------------------------------------------------------
// gptw_pkg
// Types, codes and helper functions of the guest-stage page table walker.
// ---------------------------------------------------------------------------
package gptw_pkg;

  localparam int unsigned PPN_W   = 44;
  localparam int unsigned GA_W    = 50;
  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned ENTRY_W = 64;
  localparam int unsigned ROOT_IDX_W = 11;

  localparam logic       OP_START = 1'b0;
  localparam logic       OP_ENTRY = 1'b1;
  localparam logic [1:0] LVL_ROOT = 2'd3;
  localparam logic [1:0] LVL_LAST = 2'd0;

  typedef enum logic [2:0] {
    ST_MAPPED    = 3'd0,
    ST_INVALID   = 3'd1,
    ST_ROOT_LEAF = 3'd2,
    ST_LAST_PTR  = 3'd3,
    ST_STRAY     = 3'd4
  } status_t;

  typedef struct packed {
    logic                opcode;
    logic [GA_W-1:0]     guest_address;
    logic [ENTRY_W-1:0]  table_entry;
  } in_word_t;

  typedef struct packed {
    logic                is_final;
    logic [ADDR_W-1:0]   read_address;
    status_t             status;
    logic [1:0]          leaf_level;
    logic [ADDR_W-1:0]   mapped_address;
  } out_word_t;

  // page base held in an entry: PPN field moved to a byte address
  function automatic logic [ADDR_W-1:0] entry_base(input logic [ENTRY_W-1:0] e);
    entry_base = {e[61:10], 12'h000};
  endfunction

  // table index of a level, 11 bits wide at the root and 9 bits below
  function automatic logic [ROOT_IDX_W-1:0] level_index(input logic [GA_W-1:0] ga,
                                                        input logic [1:0] lvl);
    case (lvl)
      2'd0:    level_index = {2'b00, ga[20:12]};
      2'd1:    level_index = {2'b00, ga[29:21]};
      2'd2:    level_index = {2'b00, ga[38:30]};
      default: level_index = ga[49:39];
    endcase
  endfunction

  // byte offset inside a 4K, 2M or 1G page
  function automatic logic [ADDR_W-1:0] page_offset(input logic [GA_W-1:0] ga,
                                                    input logic [1:0] lvl);
    case (lvl)
      2'd0:    page_offset = {52'h0, ga[11:0]};
      2'd1:    page_offset = {43'h0, ga[20:0]};
      default: page_offset = {34'h0, ga[29:0]};
    endcase
  endfunction

  // byte address of an entry: table base plus index times 8
  function automatic logic [ADDR_W-1:0] entry_addr(input logic [ADDR_W-1:0] base,
                                                   input logic [ROOT_IDX_W-1:0] idx);
    entry_addr = base + {50'h0, idx, 3'b000};
  endfunction

endpackage

/* rtl/gptw_in_if.sv */
// ---------------------------------------------------------------------------
// gptw_in_if
// Request channel: start words and table entry words.
// ---------------------------------------------------------------------------
interface gptw_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [gptw_pkg::GA_W-1:0]     guest_address;
  logic [gptw_pkg::ENTRY_W-1:0]  table_entry;

  modport source (output valid, opcode, guest_address, table_entry, input ready);
  modport sink   (input valid, opcode, guest_address, table_entry, output ready);
endinterface

/* rtl/gptw_out_if.sv */
// ---------------------------------------------------------------------------
// gptw_out_if
// Result channel: read requests and walk outcomes.
// ---------------------------------------------------------------------------
interface gptw_out_if;
  logic                         valid;
  logic                         ready;
  logic                         is_final;
  logic [gptw_pkg::ADDR_W-1:0]  read_address;
  logic [2:0]                   status;
  logic [1:0]                   leaf_level;
  logic [gptw_pkg::ADDR_W-1:0]  mapped_address;

  modport source (output valid, is_final, read_address, status, leaf_level,
                  mapped_address, input ready);
  modport sink   (input valid, is_final, read_address, status, leaf_level,
                  mapped_address, output ready);
endinterface

/* rtl/gstage_page_table_walker_core.sv */
// ---------------------------------------------------------------------------
// gstage_page_table_walker_core
// Guest-stage four-level page table walker, one walk step per word.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries a start word (opcode 0, guest address) or an entry word
//   (opcode 1, 64-bit table entry read back from the last requested address).
//   out_ch returns one word per input word: a read request (is_final 0, with
//   read_address) or the walk outcome (is_final 1, status, leaf level and
//   mapped address).
//   cfg_wr_en/cfg_wr_data load the root table page number; write it while
//   no walk is in flight.
//   Path: an accepted word enters the input register, then passes the step
//   into the result register once it is free, and out_ch.valid rises.
//   Throughput: one word per cycle while out_ch takes results, set by the
//   single step stage between the two registers.
//   Reset: rst_n low clears the root page number, ends any walk and empties
//   both registers.
//   Stall: while out_ch.ready is low the result holds; the input register
//   still takes one word if empty, then in_ch.ready drops until it drains.
// ---------------------------------------------------------------------------
module gstage_page_table_walker_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [gptw_pkg::PPN_W-1:0]  cfg_wr_data,
  gptw_in_if.sink                     in_ch,
  gptw_out_if.source                  out_ch
);

  logic                word_vld;
  logic                out_free;
  logic                advance;
  gptw_pkg::in_word_t  word;
  gptw_pkg::out_word_t res;

  assign advance = word_vld && out_free;

  gptw_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .advance  (advance),
    .word_vld (word_vld),
    .word     (word)
  );

  gptw_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .advance     (advance),
    .word        (word),
    .res         (res)
  );

  gptw_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .res     (res),
    .free    (out_free),
    .out_ch  (out_ch)
  );

endmodule

/* rtl/gptw_in_stage.sv */
// ---------------------------------------------------------------------------
// gptw_in_stage
// Input register: captures one request word, refills while it drains.
// ---------------------------------------------------------------------------
module gptw_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  gptw_in_if.sink            in_ch,
  input  logic               advance,
  output logic               word_vld,
  output gptw_pkg::in_word_t word
);

  logic               vld_r;
  gptw_pkg::in_word_t word_r;

  assign in_ch.ready = !vld_r || advance;
  assign word_vld    = vld_r;
  assign word        = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      word_r.opcode        <= in_ch.opcode;
      word_r.guest_address <= in_ch.guest_address;
      word_r.table_entry   <= in_ch.table_entry;
    end
  end

endmodule

/* rtl/gptw_step.sv */
// ---------------------------------------------------------------------------
// gptw_step
// Walk state and one walk step: root address, next address or outcome.
// ---------------------------------------------------------------------------
`include "gstage_page_table_walker_core_defines.svh"

module gptw_step (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [gptw_pkg::PPN_W-1:0]   cfg_wr_data,
  input  logic                         advance,
  input  gptw_pkg::in_word_t           word,
  output gptw_pkg::out_word_t          res
);

  logic [gptw_pkg::PPN_W-1:0]  root_ppn_r;
  logic                        busy_r,  busy_nxt;
  logic [1:0]                  level_r, level_nxt;
  logic [gptw_pkg::GA_W-1:0]   ga_r,    ga_nxt;
  logic [gptw_pkg::ADDR_W-1:0] base;

  assign base = gptw_pkg::entry_base(word.table_entry);

  always_comb begin
    res       = '0;
    busy_nxt  = busy_r;
    level_nxt = level_r;
    ga_nxt    = ga_r;
    if (word.opcode == gptw_pkg::OP_START) begin
      ga_nxt           = word.guest_address;
      busy_nxt         = 1'b1;
      level_nxt        = gptw_pkg::LVL_ROOT;
      res.read_address = gptw_pkg::entry_addr({8'h00, root_ppn_r, 12'h000},
                           gptw_pkg::level_index(word.guest_address, gptw_pkg::LVL_ROOT));
    end else if (!busy_r) begin
      res.is_final = 1'b1;
      res.status   = gptw_pkg::ST_STRAY;
    end else if (!word.table_entry[0]) begin
      busy_nxt     = 1'b0;
      res.is_final = 1'b1;
      res.status   = gptw_pkg::ST_INVALID;
    end else if (word.table_entry[3:1] != 3'b000) begin
      busy_nxt     = 1'b0;
      res.is_final = 1'b1;
      if (level_r == gptw_pkg::LVL_ROOT) begin
        res.status = gptw_pkg::ST_ROOT_LEAF;
      end else begin
        res.status         = gptw_pkg::ST_MAPPED;
        res.leaf_level     = level_r;
        res.mapped_address = base | gptw_pkg::page_offset(ga_r, level_r);
      end
    end else if (level_r == gptw_pkg::LVL_LAST) begin
      busy_nxt     = 1'b0;
      res.is_final = 1'b1;
      res.status   = gptw_pkg::ST_LAST_PTR;
    end else begin
      level_nxt        = level_r - 2'd1;
      res.read_address = gptw_pkg::entry_addr(base,
                           gptw_pkg::level_index(ga_r, level_r - 2'd1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_ppn_r <= '0;
      busy_r     <= 1'b0;
      level_r    <= 2'd0;
      ga_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        root_ppn_r <= cfg_wr_data;
      end
      if (advance) begin
        busy_r  <= busy_nxt;
        level_r <= level_nxt;
        ga_r    <= ga_nxt;
      end
    end
  end

  `GPTW_ASSERT_NEXT(a_final_ends_walk, advance && res.is_final, !busy_r)
  `GPTW_ASSERT_NEXT(a_start_at_root, advance && word.opcode == gptw_pkg::OP_START,
                    busy_r && level_r == gptw_pkg::LVL_ROOT)
  `GPTW_ASSERT_NOW(a_request_clean, advance && !res.is_final,
                   res.status == gptw_pkg::ST_MAPPED && res.mapped_address == '0)

endmodule

/* rtl/gptw_out_stage.sv */
// ---------------------------------------------------------------------------
// gptw_out_stage
// Result register: holds one result word until the receiver takes it.
// ---------------------------------------------------------------------------
module gptw_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  gptw_pkg::out_word_t res,
  output logic                free,
  gptw_out_if.source          out_ch
);

  logic                vld_r;
  gptw_pkg::out_word_t res_r;

  assign free                  = !vld_r || out_ch.ready;
  assign out_ch.valid          = vld_r;
  assign out_ch.is_final       = res_r.is_final;
  assign out_ch.read_address   = res_r.read_address;
  assign out_ch.status         = res_r.status;
  assign out_ch.leaf_level     = res_r.leaf_level;
  assign out_ch.mapped_address = res_r.mapped_address;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

endmodule
